// File: rtl/arf_pkg.sv
package arf_pkg;

    localparam int ARF_RING_WORDS = 8192;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int INC_W      = 32;
    localparam int MOD_W      = 52;
    localparam int ACC_W      = 53;
    localparam int WORK_W     = ACC_W + 1;
    localparam int FMT_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MOD_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS = MOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_W-1:0] MIDSCALE = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_COPY_INCREMENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_MODULUS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_OUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_ON       = 3'd4;

    localparam logic [FMT_W-1:0] FMT_U8     = 3'd0;
    localparam logic [FMT_W-1:0] FMT_S8     = 3'd1;
    localparam logic [FMT_W-1:0] FMT_U16SYS = 3'd2;
    localparam logic [FMT_W-1:0] FMT_S16SYS = 3'd3;
    localparam logic [FMT_W-1:0] FMT_U16LSB = 3'd4;
    localparam logic [FMT_W-1:0] FMT_S16LSB = 3'd5;
    localparam logic [FMT_W-1:0] FMT_U16MSB = 3'd6;
    localparam logic [FMT_W-1:0] FMT_S16MSB = 3'd7;
    localparam int FMT_SIGNED_BIT = 0;

    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } q_item_t;

    typedef struct packed {
        logic [INC_W-1:0] copy_increment;
        logic [MOD_W-1:0] copy_modulus;
        logic [FMT_W-1:0] output_format;
        logic             stereo_out;
        logic             sound_on;
        logic             clear_acc;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [BYTE_W-1:0] byte_c;
        logic [BYTE_W-1:0] byte_d;
        logic [CNT_W-1:0]  byte_count;
    } fmt_out_t;

    function automatic fmt_out_t format_frame(
        input logic [SAMPLE_W-1:0] left,
        input logic [SAMPLE_W-1:0] right,
        input logic [FMT_W-1:0]    fmt,
        input logic                stereo
    );
        fmt_out_t            o;
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
        l = stereo ? left : ({1'b0, left[SAMPLE_W-1:1]} + {1'b0, right[SAMPLE_W-1:1]});
        r = right;
        if (fmt[FMT_SIGNED_BIT])
        begin
            l = l - MIDSCALE;
            r = r - MIDSCALE;
        end
        o = '0;
        case (fmt) inside
            FMT_U8, FMT_S8:
            begin
                o.byte_a = l[15:8];
                if (stereo)
                begin
                    o.byte_b     = r[15:8];
                    o.byte_count = CNT_TWO;
                end
                else
                begin
                    o.byte_count = CNT_ONE;
                end
            end
            FMT_U16MSB, FMT_S16MSB:
            begin
                o.byte_a = l[15:8];
                o.byte_b = l[7:0];
                if (stereo)
                begin
                    o.byte_c     = r[15:8];
                    o.byte_d     = r[7:0];
                    o.byte_count = CNT_FOUR;
                end
                else
                begin
                    o.byte_count = CNT_TWO;
                end
            end
            default:
            begin
                o.byte_a = l[7:0];
                o.byte_b = l[15:8];
                if (stereo)
                begin
                    o.byte_c     = r[7:0];
                    o.byte_d     = r[15:8];
                    o.byte_count = CNT_FOUR;
                end
                else
                begin
                    o.byte_count = CNT_TWO;
                end
            end
        endcase
        return o;
    endfunction

endpackage

// File: rtl/arf_ifs.sv
interface arf_req_if import arf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [SAMPLE_W-1:0] left_in;
    logic [SAMPLE_W-1:0] right_in;

    modport source (output valid, func, left_in, right_in, input ready);
    modport sink (input valid, func, left_in, right_in, output ready);
endinterface

interface arf_rsp_if import arf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic [BYTE_W-1:0] byte_c;
    logic [BYTE_W-1:0] byte_d;
    logic [CNT_W-1:0]  byte_count;
    logic              underrun;

    modport source (output valid, byte_a, byte_b, byte_c, byte_d, byte_count, underrun,
                    input ready);
    modport sink (input valid, byte_a, byte_b, byte_c, byte_d, byte_count, underrun,
                  output ready);
endinterface

// File: rtl/audio_repeat_fifo_formatter.sv
// pull: on underrun the result is registered after the queue; from the ring it also passes the registered read (S_PULL)
// push: one ring write per copy; past a full ring of copies the
//   remaining count comes from a bit-serial divider (S_DIV), then S_FIX moves the write slot
// back end takes no new item during a push's copies or a ring pull's registered read; an underrun pull stays in S_IDLE
// reset: accumulator, slots and queue cleared, held frame midscale, configuration to defaults;
//   ring contents undefined until written, no clearing pass
module audio_repeat_fifo_formatter import arf_pkg::*; #(
    parameter int RING_WORDS = ARF_RING_WORDS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    arf_req_if.sink               req,
    arf_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [INC_W-1:0] inc_reg, inc_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [FMT_W-1:0] fmt_reg, fmt_next;
    logic             stereo_reg, stereo_next;
    logic             sound_reg, sound_next;
    logic             clear_acc;
    cfg_t             cfg;
    logic             item_valid;
    q_item_t          item;
    logic             item_ready;

    always_comb
    begin
        inc_next    = inc_reg;
        mod_next    = mod_reg;
        fmt_next    = fmt_reg;
        stereo_next = stereo_reg;
        sound_next  = sound_reg;
        clear_acc   = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COPY_INCREMENT:
                begin
                    inc_next  = cfg_data[INC_W-1:0];
                    clear_acc = 1'b1;
                end
                REG_COPY_MODULUS:
                begin
                    mod_next  = cfg_data[MOD_W-1:0];
                    clear_acc = 1'b1;
                end
                REG_OUTPUT_FORMAT: fmt_next    = cfg_data[FMT_W-1:0];
                REG_STEREO_OUT:    stereo_next = cfg_data[0];
                REG_SOUND_ON:      sound_next  = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg    <= '0;
            mod_reg    <= '0;
            fmt_reg    <= FMT_S16SYS;
            stereo_reg <= 1'b1;
            sound_reg  <= 1'b1;
        end
        else
        begin
            inc_reg    <= inc_next;
            mod_reg    <= mod_next;
            fmt_reg    <= fmt_next;
            stereo_reg <= stereo_next;
            sound_reg  <= sound_next;
        end
    end

    assign cfg.copy_increment = inc_reg;
    assign cfg.copy_modulus   = mod_reg;
    assign cfg.output_format  = fmt_reg;
    assign cfg.stereo_out     = stereo_reg;
    assign cfg.sound_on       = sound_reg;
    assign cfg.clear_acc      = clear_acc;

    arf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    arf_back #(
        .RING_FRAMES (RING_WORDS / 2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .rsp        (rsp)
    );

endmodule

// File: rtl/arf_ram.sv
module arf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/arf_front.sv
module arf_front import arf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    arf_req_if.sink    req,
    output logic       item_valid,
    output q_item_t    item,
    input  logic       item_ready
);

    q_item_t              queue_reg [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0]   wr_ptr_reg;
    logic [Q_IDX_W-1:0]   wr_ptr_next;
    logic [Q_IDX_W-1:0]   rd_ptr_reg;
    logic [Q_IDX_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 accept;
    logic                 keep;
    logic                 pop;
    q_item_t              in_item;

    assign req.ready  = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign accept     = req.valid && req.ready;
    assign in_item.op    = op_t'(req.func);
    assign in_item.left  = req.left_in;
    assign in_item.right = req.right_in;

    // a push with no increment leaves every piece of state alone
    assign keep = accept && !(in_item.op == OP_PUSH && cfg.copy_increment == '0);

    assign item_valid = (count_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = keep ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(keep) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/arf_back.sv
module arf_back import arf_pkg::*; #(
    parameter int RING_FRAMES = ARF_RING_WORDS / 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       item_valid,
    input  q_item_t    item,
    output logic       item_ready,
    arf_rsp_if.source  rsp
);

    localparam int SLOT_W   = $clog2(RING_FRAMES);
    localparam int WR_CNT_W = $clog2(RING_FRAMES + 1);
    localparam logic [WR_CNT_W-1:0] RING_FULL   = WR_CNT_W'(RING_FRAMES);
    localparam logic [SLOT_W:0]     FRAMES_EXT  = (SLOT_W + 1)'(RING_FRAMES);
    localparam logic [SLOT_W-1:0]   LAST_SLOT   = SLOT_W'(RING_FRAMES - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COPY = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_PULL = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [ACC_W-1:0]      accum_reg, accum_next;
    logic [WORK_W-1:0]     acc_work_reg, acc_work_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [SLOT_W-1:0]     wp_reg, wp_next;
    logic [SLOT_W-1:0]     rp_reg, rp_next;
    logic [SAMPLE_W-1:0]   held_l_reg, held_l_next;
    logic [SAMPLE_W-1:0]   held_r_reg, held_r_next;
    logic [WR_CNT_W-1:0]   written_reg, written_next;
    logic [INC_W:0]        div_rem_reg, div_rem_next;
    logic [MOD_W-1:0]      div_dvd_reg, div_dvd_next;
    logic [SLOT_W-1:0]     div_q_reg, div_q_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    fmt_out_t              out_data_reg, out_data_next;
    logic                  out_under_reg, out_under_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [FRAME_W-1:0]    ram_rdata;

    logic                  out_free;
    logic                  acc_lt;
    logic [INC_W:0]        div_trial;
    logic                  div_ge;
    logic [SLOT_W:0]       div_q_dbl;
    logic                  rem_nz;
    logic [SLOT_W-1:0]     fix_count;
    logic [SLOT_W:0]       fix_sum;
    logic [SAMPLE_W-1:0]   held_l_eff;
    logic [SAMPLE_W-1:0]   held_r_eff;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    arf_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (RING_FRAMES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (frame_reg),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || rsp.ready;
    assign acc_lt     = acc_work_reg < WORK_W'(cfg.copy_modulus);
    assign div_trial  = {div_rem_reg[INC_W-1:0], div_dvd_reg[MOD_W-1]};
    assign div_ge     = div_trial >= (INC_W + 1)'(cfg.copy_increment);
    assign div_q_dbl  = {div_q_reg, div_ge};
    assign rem_nz     = (div_rem_reg != '0);
    assign fix_count  = rem_nz ? slot_inc(div_q_reg) : div_q_reg;
    assign fix_sum    = {1'b0, wp_reg} + {1'b0, fix_count};
    assign held_l_eff = cfg.sound_on ? held_l_reg : MIDSCALE;
    assign held_r_eff = cfg.sound_on ? held_r_reg : MIDSCALE;

    always_comb
    begin
        state_next     = state_reg;
        accum_next     = accum_reg;
        acc_work_next  = acc_work_reg;
        frame_next     = frame_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        held_l_next    = held_l_reg;
        held_r_next    = held_r_reg;
        written_next   = written_reg;
        div_rem_next   = div_rem_reg;
        div_dvd_next   = div_dvd_reg;
        div_q_next     = div_q_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        out_under_next = out_under_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        item_ready     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.op == OP_PUSH)
                    begin
                        item_ready    = 1'b1;
                        acc_work_next = WORK_W'(accum_reg) + WORK_W'(cfg.copy_increment);
                        frame_next    = {item.left, item.right};
                        written_next  = '0;
                        state_next    = S_COPY;
                    end
                    else if (out_free)
                    begin
                        item_ready = 1'b1;
                        if (rp_reg == wp_reg)
                        begin
                            held_l_next    = held_l_eff;
                            held_r_next    = held_r_eff;
                            out_valid_next = 1'b1;
                            out_data_next  = format_frame(held_l_eff, held_r_eff,
                                                          cfg.output_format, cfg.stereo_out);
                            out_under_next = 1'b1;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            rp_next    = slot_inc(rp_reg);
                            state_next = S_PULL;
                        end
                    end
                end
            end
            S_PULL:
            begin
                held_l_next    = ram_rdata[FRAME_W-1:SAMPLE_W];
                held_r_next    = ram_rdata[SAMPLE_W-1:0];
                out_valid_next = 1'b1;
                out_data_next  = format_frame(ram_rdata[FRAME_W-1:SAMPLE_W],
                                              ram_rdata[SAMPLE_W-1:0],
                                              cfg.output_format, cfg.stereo_out);
                out_under_next = 1'b0;
                state_next     = S_IDLE;
            end
            S_COPY:
            begin
                if (acc_lt)
                begin
                    if (written_reg == RING_FULL)
                    begin
                        // every slot holds the frame; the rest only moves the write slot
                        div_rem_next = '0;
                        div_dvd_next = cfg.copy_modulus - acc_work_reg[MOD_W-1:0];
                        div_q_next   = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        ram_we        = 1'b1;
                        wp_next       = slot_inc(wp_reg);
                        acc_work_next = acc_work_reg + WORK_W'(cfg.copy_increment);
                        written_next  = written_reg + 1'b1;
                    end
                end
                else
                begin
                    accum_next = ACC_W'(acc_work_reg - WORK_W'(cfg.copy_modulus));
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                div_rem_next = div_ge ? div_trial - (INC_W + 1)'(cfg.copy_increment)
                                      : div_trial;
                div_dvd_next = {div_dvd_reg[MOD_W-2:0], 1'b0};
                // quotient kept modulo the ring size
                div_q_next   = (div_q_dbl >= FRAMES_EXT) ? SLOT_W'(div_q_dbl - FRAMES_EXT)
                                                         : SLOT_W'(div_q_dbl);
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                wp_next    = (fix_sum >= FRAMES_EXT) ? SLOT_W'(fix_sum - FRAMES_EXT)
                                                     : SLOT_W'(fix_sum);
                accum_next = rem_nz ? ACC_W'((INC_W + 1)'(cfg.copy_increment) - div_rem_reg)
                                    : '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.clear_acc)
        begin
            accum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            accum_reg     <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            held_l_reg    <= MIDSCALE;
            held_r_reg    <= MIDSCALE;
            written_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            held_l_reg    <= held_l_next;
            held_r_reg    <= held_r_next;
            written_reg   <= written_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_work_reg  <= acc_work_next;
        frame_reg     <= frame_next;
        div_rem_reg   <= div_rem_next;
        div_dvd_reg   <= div_dvd_next;
        div_q_reg     <= div_q_next;
        out_data_reg  <= out_data_next;
        out_under_reg <= out_under_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.byte_a     = out_data_reg.byte_a;
    assign rsp.byte_b     = out_data_reg.byte_b;
    assign rsp.byte_c     = out_data_reg.byte_c;
    assign rsp.byte_d     = out_data_reg.byte_d;
    assign rsp.byte_count = out_data_reg.byte_count;
    assign rsp.underrun   = out_under_reg;

endmodule
